// File: sv/oqu_pkg.sv
// Package for the orientation quaternion update: widths, constants, sequencer states and the product term table.
package oqu_pkg;

  localparam int FIELD_W   = 16;
  localparam int FRAC_BITS = 14;
  localparam logic [FIELD_W-1:0] ONE_VAL = FIELD_W'(1) << FRAC_BITS;

  // The largest normalized magnitude lies in [2^NORM_BIT, 2^(NORM_BIT+1)).
  localparam int NORM_BIT = 29;
  localparam int NMAG_W   = NORM_BIT + 1;

  // Product accumulators and raw magnitudes.
  localparam int ACC_W  = 34;
  localparam int MAG_W  = 32;

  // Shared multiplier operands and result.
  localparam int MOP_W  = NMAG_W + 1;
  localparam int MRES_W = 2 * MOP_W;

  // Sum of squares, square root and division.
  localparam int SUM_W  = 2 * NMAG_W + 2;
  localparam int ROOT_W = NMAG_W + 1;
  localparam int QUO_W  = FRAC_BITS + 1;
  localparam int NUM_W  = NMAG_W + FRAC_BITS + 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_MAG,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_DLOAD,
    ST_DSTEP,
    ST_FWD,
    ST_FIN
  } oqu_state_t;

  // One term of the Hamilton product: orientation word, delta word, subtract.
  typedef struct packed {
    logic [1:0] pi;
    logic [1:0] qi;
    logic       neg;
  } oqu_term_t;

  // Term table, indexed by component * 4 + term.
  function automatic oqu_term_t term_of(input logic [3:0] idx);
    oqu_term_t t;
    unique case (idx)
      4'd0:  t = '{pi: 2'd0, qi: 2'd0, neg: 1'b0};
      4'd1:  t = '{pi: 2'd1, qi: 2'd1, neg: 1'b1};
      4'd2:  t = '{pi: 2'd2, qi: 2'd2, neg: 1'b1};
      4'd3:  t = '{pi: 2'd3, qi: 2'd3, neg: 1'b1};
      4'd4:  t = '{pi: 2'd0, qi: 2'd1, neg: 1'b0};
      4'd5:  t = '{pi: 2'd1, qi: 2'd0, neg: 1'b0};
      4'd6:  t = '{pi: 2'd2, qi: 2'd3, neg: 1'b0};
      4'd7:  t = '{pi: 2'd3, qi: 2'd2, neg: 1'b1};
      4'd8:  t = '{pi: 2'd0, qi: 2'd2, neg: 1'b0};
      4'd9:  t = '{pi: 2'd2, qi: 2'd0, neg: 1'b0};
      4'd10: t = '{pi: 2'd3, qi: 2'd1, neg: 1'b0};
      4'd11: t = '{pi: 2'd1, qi: 2'd3, neg: 1'b1};
      4'd12: t = '{pi: 2'd0, qi: 2'd3, neg: 1'b0};
      4'd13: t = '{pi: 2'd3, qi: 2'd0, neg: 1'b0};
      4'd14: t = '{pi: 2'd1, qi: 2'd2, neg: 1'b0};
      4'd15: t = '{pi: 2'd2, qi: 2'd1, neg: 1'b1};
    endcase
    return t;
  endfunction

endpackage

// File: sv/oqu_in_if.sv
// Request channel carrying one delta quaternion.
interface oqu_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [oqu_pkg::FIELD_W-1:0]   delta_w;
  logic signed [oqu_pkg::FIELD_W-1:0]   delta_x;
  logic signed [oqu_pkg::FIELD_W-1:0]   delta_y;
  logic signed [oqu_pkg::FIELD_W-1:0]   delta_z;

  modport source (output valid, delta_w, delta_x, delta_y, delta_z, input ready);
  modport sink   (input valid, delta_w, delta_x, delta_y, delta_z, output ready);
endinterface

// File: sv/oqu_out_if.sv
// Result channel carrying the new orientation, forward term and direction flags.
interface oqu_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [oqu_pkg::FIELD_W-1:0]   orient_w;
  logic signed [oqu_pkg::FIELD_W-1:0]   orient_x;
  logic signed [oqu_pkg::FIELD_W-1:0]   orient_y;
  logic signed [oqu_pkg::FIELD_W-1:0]   orient_z;
  logic signed [oqu_pkg::FIELD_W-1:0]   forward_term;
  logic                                 dir_x_negative;
  logic                                 dir_y_negative;

  modport source (output valid, orient_w, orient_x, orient_y, orient_z, forward_term,
                  dir_x_negative, dir_y_negative, input ready);
  modport sink   (input valid, orient_w, orient_x, orient_y, orient_z, forward_term,
                  dir_x_negative, dir_y_negative, output ready);
endinterface

// File: sv/orientation_quaternion_update.sv
// Orientation quaternion update: multiply by a delta quaternion and renormalize.
// The block holds an orientation quaternion in Q2.14 that resets to identity. Each delta
// request is multiplied in (orientation * delta), the product is scaled back to unit
// length, and the new orientation comes out with the forward term 2*y*w and the two
// direction flags. One shared 31x31 multiplier does the sixteen product terms, the four
// squares and the forward term; the square root and the four divisions run bit by bit.
// A request is accepted, then passes through the product, the magnitude step, a shift that
// brings the largest component into range one bit per cycle, the squares, the root, the
// four 15-bit divisions, the forward term and the hand-off. A product of zero length goes
// from the magnitude step to the forward term. The block takes no request while one
// is in progress, but it does take the next one while a finished result still waits on
// the result channel; a second finished result then waits until the first is taken.
module orientation_quaternion_update (
  input  logic             clk,
  input  logic             rst,
  oqu_in_if.sink           delta,
  oqu_out_if.source        result
);

  localparam int FW = oqu_pkg::FIELD_W;
  localparam int FB = oqu_pkg::FRAC_BITS;
  localparam int QW = oqu_pkg::QUO_W;

  oqu_pkg::oqu_state_t state, state_next;
  logic [4:0] step;

  logic signed [FW-1:0]                 qd     [4];
  logic signed [FW-1:0]                 orient [4];
  logic signed [oqu_pkg::ACC_W-1:0]     acc    [4];
  logic [oqu_pkg::MAG_W-1:0]            mag    [4];
  logic [oqu_pkg::MAG_W-1:0]            maxm;

  logic [oqu_pkg::SUM_W-1:0]            sq_rem;
  logic [63:0]                          root;
  logic [oqu_pkg::SUM_W:0]              sbit;

  logic [1:0]                           comp;
  logic [QW-1:0]                        num_lo;
  logic [oqu_pkg::ROOT_W-1:0]           rem;
  logic [QW-1:0]                        quo;

  logic signed [oqu_pkg::MOP_W-1:0]     mul_a, mul_b;
  logic signed [oqu_pkg::MRES_W-1:0]    mul_q;

  logic                                 out_valid;
  logic signed [FW-1:0]                 out_w, out_x, out_y, out_z, out_fwd;
  logic                                 out_dx, out_dy;

  // Combinational helpers.
  oqu_pkg::oqu_term_t                   cur_term, prev_term;
  logic [3:0]                           prev_idx;
  logic [oqu_pkg::MAG_W-1:0]            acc_mag [4];
  logic [oqu_pkg::MAG_W-1:0]            max01, max23, max_all;
  logic                                 prod_zero;
  logic [63:0]                          trial;
  logic                                 trial_ok;
  logic [oqu_pkg::ROOT_W-1:0]           r_val;
  logic [oqu_pkg::NUM_W-1:0]            num;
  logic [oqu_pkg::ROOT_W:0]             rem2;
  logic                                 div_ge;
  logic [QW-1:0]                        quo_next;
  logic [QW-1:0]                        n_sat;
  logic [FW-2:0]                        aw, ay;
  logic [oqu_pkg::MOP_W-1:0]            fsum;
  logic [oqu_pkg::MOP_W-FB-1:0]         fmag;
  logic [FW-1:0]                        fsat;
  logic signed [FW-1:0]                 fwd;
  logic                                 out_free;

  always_comb begin
    cur_term  = oqu_pkg::term_of(step[3:0]);
    prev_idx  = 4'(step - 5'd1);
    prev_term = oqu_pkg::term_of(prev_idx);

    for (int i = 0; i < 4; i++) begin
      acc_mag[i] = acc[i][oqu_pkg::ACC_W-1] ? oqu_pkg::MAG_W'(-acc[i])
                                            : oqu_pkg::MAG_W'(acc[i]);
    end
    max01     = (acc_mag[0] > acc_mag[1]) ? acc_mag[0] : acc_mag[1];
    max23     = (acc_mag[2] > acc_mag[3]) ? acc_mag[2] : acc_mag[3];
    max_all   = (max01 > max23) ? max01 : max23;
    prod_zero = (max_all == '0);

    trial    = root + 64'(sbit);
    trial_ok = 64'(sq_rem) >= trial;

    r_val = root[oqu_pkg::ROOT_W-1:0];
    num   = {1'b0, mag[comp][oqu_pkg::NMAG_W-1:0], FB'(0)}
          + oqu_pkg::NUM_W'(r_val >> 1);

    rem2     = {rem, num_lo[QW-1]};
    div_ge   = rem2 >= {1'b0, r_val};
    quo_next = {quo[QW-2:0], div_ge};
    n_sat    = (quo_next > QW'(oqu_pkg::ONE_VAL)) ? QW'(oqu_pkg::ONE_VAL) : quo_next;

    aw = orient[0][FW-1] ? (FW-1)'(-orient[0]) : (FW-1)'(orient[0]);
    ay = orient[2][FW-1] ? (FW-1)'(-orient[2]) : (FW-1)'(orient[2]);

    // Twice the product, rounded half away from zero on the magnitude.
    fsum = {mul_q[oqu_pkg::MOP_W-2:0], 1'b0} + (oqu_pkg::MOP_W'(1) << (FB - 1));
    fmag = fsum[oqu_pkg::MOP_W-1:FB];
    fsat = (fmag > (oqu_pkg::MOP_W-FB)'(oqu_pkg::ONE_VAL)) ? oqu_pkg::ONE_VAL
                                                           : FW'(fmag);
    fwd  = (orient[0][FW-1] != orient[2][FW-1]) ? -$signed(fsat) : $signed(fsat);

    out_free = !out_valid || result.ready;
  end

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      oqu_pkg::ST_MUL: begin
        mul_a = oqu_pkg::MOP_W'(orient[cur_term.pi]);
        mul_b = oqu_pkg::MOP_W'(qd[cur_term.qi]);
      end
      oqu_pkg::ST_SQ: begin
        mul_a = {1'b0, mag[step[1:0]][oqu_pkg::NMAG_W-1:0]};
        mul_b = {1'b0, mag[step[1:0]][oqu_pkg::NMAG_W-1:0]};
      end
      oqu_pkg::ST_FWD, oqu_pkg::ST_FIN: begin
        // Held through the hand-off so the forward term stays put while it waits.
        mul_a = oqu_pkg::MOP_W'(aw);
        mul_b = oqu_pkg::MOP_W'(ay);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oqu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    delta.ready = 1'b0;
    unique case (state)
      oqu_pkg::ST_IDLE: begin
        delta.ready = 1'b1;
        if (delta.valid) state_next = oqu_pkg::ST_MUL;
      end
      oqu_pkg::ST_MUL: begin
        if (step == 5'd16) state_next = oqu_pkg::ST_MAG;
      end
      oqu_pkg::ST_MAG: begin
        state_next = prod_zero ? oqu_pkg::ST_FWD : oqu_pkg::ST_NORM;
      end
      oqu_pkg::ST_NORM: begin
        if (maxm[oqu_pkg::MAG_W-1:oqu_pkg::NORM_BIT+1] == '0 && maxm[oqu_pkg::NORM_BIT])
          state_next = oqu_pkg::ST_SQ;
      end
      oqu_pkg::ST_SQ: begin
        if (step == 5'd4) state_next = oqu_pkg::ST_SQRT;
      end
      oqu_pkg::ST_SQRT: begin
        if (step == 5'd31) state_next = oqu_pkg::ST_DLOAD;
      end
      oqu_pkg::ST_DLOAD: begin
        state_next = oqu_pkg::ST_DSTEP;
      end
      oqu_pkg::ST_DSTEP: begin
        if (step == 5'(QW - 1))
          state_next = (comp == 2'd3) ? oqu_pkg::ST_FWD : oqu_pkg::ST_DLOAD;
      end
      oqu_pkg::ST_FWD: begin
        state_next = oqu_pkg::ST_FIN;
      end
      oqu_pkg::ST_FIN: begin
        if (out_free) state_next = oqu_pkg::ST_IDLE;
      end
      default: begin
        state_next = oqu_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer step counter restarts on every state change.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (state_next != state) begin
      step <= '0;
    end else begin
      step <= step + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      orient[0] <= $signed(oqu_pkg::ONE_VAL);
      orient[1] <= '0;
      orient[2] <= '0;
      orient[3] <= '0;
      comp      <= '0;
    end else begin
      unique case (state)
        oqu_pkg::ST_IDLE: begin
          if (delta.valid) begin
            qd[0] <= delta.delta_w;
            qd[1] <= delta.delta_x;
            qd[2] <= delta.delta_y;
            qd[3] <= delta.delta_z;
            for (int i = 0; i < 4; i++) acc[i] <= '0;
            comp <= '0;
          end
        end
        oqu_pkg::ST_MUL: begin
          // The multiplier output is registered, so each step accumulates the term at prev_idx.
          if (step != 5'd0) begin
            if (prev_term.neg)
              acc[prev_idx[3:2]] <= acc[prev_idx[3:2]] - oqu_pkg::ACC_W'(mul_q);
            else
              acc[prev_idx[3:2]] <= acc[prev_idx[3:2]] + oqu_pkg::ACC_W'(mul_q);
          end
        end
        oqu_pkg::ST_MAG: begin
          for (int i = 0; i < 4; i++) mag[i] <= acc_mag[i];
          maxm <= max_all;
          if (prod_zero) begin
            orient[0] <= $signed(oqu_pkg::ONE_VAL);
            orient[1] <= '0;
            orient[2] <= '0;
            orient[3] <= '0;
          end
        end
        oqu_pkg::ST_NORM: begin
          if (maxm[oqu_pkg::MAG_W-1:oqu_pkg::NORM_BIT+1] != '0) begin
            for (int i = 0; i < 4; i++) mag[i] <= mag[i] >> 1;
            maxm <= maxm >> 1;
          end else if (!maxm[oqu_pkg::NORM_BIT]) begin
            for (int i = 0; i < 4; i++) mag[i] <= mag[i] << 1;
            maxm <= maxm << 1;
          end
        end
        oqu_pkg::ST_SQ: begin
          if (step == 5'd0) begin
            sq_rem <= '0;
          end else begin
            sq_rem <= sq_rem + oqu_pkg::SUM_W'(mul_q);
          end
          root <= '0;
          sbit <= (oqu_pkg::SUM_W+1)'(1) << oqu_pkg::SUM_W;
        end
        oqu_pkg::ST_SQRT: begin
          if (trial_ok) begin
            sq_rem <= oqu_pkg::SUM_W'(64'(sq_rem) - trial);
            root   <= (root >> 1) + 64'(sbit);
          end else begin
            root   <= root >> 1;
          end
          sbit <= sbit >> 2;
        end
        oqu_pkg::ST_DLOAD: begin
          rem    <= oqu_pkg::ROOT_W'(num[oqu_pkg::NUM_W-1:QW]);
          num_lo <= num[QW-1:0];
          quo    <= '0;
        end
        oqu_pkg::ST_DSTEP: begin
          rem    <= div_ge ? oqu_pkg::ROOT_W'(rem2 - {1'b0, r_val})
                           : oqu_pkg::ROOT_W'(rem2);
          quo    <= quo_next;
          num_lo <= num_lo << 1;
          if (step == 5'(QW - 1)) begin
            orient[comp] <= acc[comp][oqu_pkg::ACC_W-1] ? -$signed(FW'(n_sat))
                                                        : $signed(FW'(n_sat));
            comp <= comp + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register; a finished result waits here until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == oqu_pkg::ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == oqu_pkg::ST_FIN && out_free) begin
      out_w   <= orient[0];
      out_x   <= orient[1];
      out_y   <= orient[2];
      out_z   <= orient[3];
      out_fwd <= fwd;
      out_dx  <= ay > (FW-1)'(3 * (oqu_pkg::ONE_VAL >> 2));
      out_dy  <= aw < (FW-1)'(oqu_pkg::ONE_VAL >> 1);
    end
  end

  assign result.valid          = out_valid;
  assign result.orient_w       = out_w;
  assign result.orient_x       = out_x;
  assign result.orient_y       = out_y;
  assign result.orient_z       = out_z;
  assign result.forward_term   = out_fwd;
  assign result.dir_x_negative = out_dx;
  assign result.dir_y_negative = out_dy;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the orientation quaternion update block.
module tb_top;

  localparam int FW          = oqu_pkg::FIELD_W;
  localparam int FB          = oqu_pkg::FRAC_BITS;
  localparam int N_DIRECTED  = 22;
  localparam int N_RANDOM    = 1950;
  localparam int N_TOTAL     = N_DIRECTED + N_RANDOM;
  localparam int QUIET_FROM  = N_TOTAL - 150;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 1500;
  localparam int DRAIN_A     = 800;
  localparam int DRAIN_B     = 1500;
  localparam int TAIL_CYCLES = 200;
  localparam longint unsigned UNIT = 64'd1 << FB;

  typedef enum int {K_RAW, K_UNIT, K_NEAR_ID, K_TINY, K_EXTREME, K_ZERO} delta_kind_t;

  typedef struct {
    logic signed [FW-1:0] w;
    logic signed [FW-1:0] x;
    logic signed [FW-1:0] y;
    logic signed [FW-1:0] z;
    int                   gap;
    bit                   drain;
  } delta_req_t;

  typedef struct packed {
    logic signed [FW-1:0] w;
    logic signed [FW-1:0] x;
    logic signed [FW-1:0] y;
    logic signed [FW-1:0] z;
    logic signed [FW-1:0] fwd;
    logic                 dir_x_neg;
    logic                 dir_y_neg;
  } orient_t;

  logic clk;
  logic rst;

  oqu_in_if  delta_if ();
  oqu_out_if result_if ();

  orientation_quaternion_update u_top (
    .clk    (clk),
    .rst    (rst),
    .delta  (delta_if),
    .result (result_if)
  );

  delta_req_t pending_deltas[$];
  orient_t    due_orients[$];
  longint     att[4];
  int         n_sent;
  int         n_errors;
  int         n_results;
  int         gap_left;
  bit         gap_armed;
  int         hold_left;
  bit         hold_done;
  int         rx_gap;
  int         calm_left;

  initial begin : clock_gen
    clk = 1'b0;
    rst = 1'b1;
    delta_if.valid   = 1'b0;
    delta_if.delta_w = '0;
    delta_if.delta_x = '0;
    delta_if.delta_y = '0;
    delta_if.delta_z = '0;
    result_if.ready  = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    #24000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned s);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Multiplies the tracked orientation by one delta, renormalizes it and
  // returns the result the block should produce.
  function automatic orient_t apply_delta(delta_req_t d);
    longint q[4];
    longint prod[4];
    longint unsigned mag[4];
    longint unsigned peak, m, sum, root, n, aw, ay, f;
    longint fwd;
    int lsh, rsh;
    orient_t o;
    q[0] = longint'(d.w);
    q[1] = longint'(d.x);
    q[2] = longint'(d.y);
    q[3] = longint'(d.z);
    prod[0] = att[0] * q[0] - att[1] * q[1] - att[2] * q[2] - att[3] * q[3];
    prod[1] = att[0] * q[1] + att[1] * q[0] + att[2] * q[3] - att[3] * q[2];
    prod[2] = att[0] * q[2] + att[2] * q[0] + att[3] * q[1] - att[1] * q[3];
    prod[3] = att[0] * q[3] + att[3] * q[0] + att[1] * q[2] - att[2] * q[1];
    peak = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = (prod[i] < 0) ? longint'(-prod[i]) : longint'(prod[i]);
      if (mag[i] > peak) peak = mag[i];
    end
    if (peak == 0) begin
      // A zero-length product falls back to the identity.
      att[0] = longint'(UNIT);
      att[1] = 0;
      att[2] = 0;
      att[3] = 0;
    end else begin
      lsh = 0;
      rsh = 0;
      m = peak;
      while (m < (64'd1 << 29)) begin
        m <<= 1;
        lsh++;
      end
      while (m >= (64'd1 << 30)) begin
        m >>= 1;
        rsh++;
      end
      sum = 0;
      for (int i = 0; i < 4; i++) begin
        mag[i] = (mag[i] << lsh) >> rsh;
        sum += mag[i] * mag[i];
      end
      root = floor_sqrt(sum);
      if (root == 0) root = 1;
      for (int i = 0; i < 4; i++) begin
        n = (mag[i] * UNIT + (root >> 1)) / root;
        if (n > UNIT) n = UNIT;
        att[i] = (prod[i] < 0) ? -longint'(n) : longint'(n);
      end
    end
    aw = (att[0] < 0) ? longint'(-att[0]) : longint'(att[0]);
    ay = (att[2] < 0) ? longint'(-att[2]) : longint'(att[2]);
    f = (2 * aw * ay + (64'd1 << (FB - 1))) >> FB;
    if (f > UNIT) f = UNIT;
    fwd = ((att[0] < 0) != (att[2] < 0)) ? -longint'(f) : longint'(f);
    o.w = FW'(att[0]);
    o.x = FW'(att[1]);
    o.y = FW'(att[2]);
    o.z = FW'(att[3]);
    o.fwd = FW'(fwd);
    o.dir_x_neg = (ay > 3 * (UNIT >> 2));
    o.dir_y_neg = (aw < (UNIT >> 1));
    return o;
  endfunction

  function automatic void push_req(int w, int x, int y, int z, int gap, bit drain);
    delta_req_t r;
    r.w = FW'(w);
    r.x = FW'(x);
    r.y = FW'(y);
    r.z = FW'(z);
    r.gap = gap;
    r.drain = drain;
    pending_deltas.push_back(r);
  endfunction

  function automatic int pick_field(delta_kind_t kind, int idx);
    int b;
    case (kind)
      K_RAW: return int'($urandom_range(0, 65535)) - 32768;
      K_UNIT: return int'($urandom_range(0, 32768)) - 16384;
      K_NEAR_ID: begin
        if (idx == 0) return 16384 - int'($urandom_range(0, 1500));
        return int'($urandom_range(0, 1200)) - 600;
      end
      K_TINY: begin
        b = $urandom_range(0, 6);
        return int'($urandom_range(0, 1 << b)) * ($urandom_range(0, 1) ? -1 : 1);
      end
      K_EXTREME: begin
        case ($urandom_range(0, 6))
          0: return 0;
          1: return 16384;
          2: return -16384;
          3: return 32767;
          4: return -32768;
          5: return 1;
          default: return -1;
        endcase
      end
      default: return 0;
    endcase
  endfunction

  function automatic void report_error(string what);
    n_errors++;
    if (n_errors <= 10) $display("ERROR: %s", what);
  endfunction

  initial begin : stimulus
    int pct;
    int gap;
    bit calm;
    delta_kind_t kind;
    att[0] = longint'(UNIT);
    att[1] = 0;
    att[2] = 0;
    att[3] = 0;
    n_errors = 0;

    // Directed part: identity, zero length, axis rotations, out-of-range
    // patterns and tiny deltas that need the largest normalizing shift.
    push_req(16384, 0, 0, 0, 0, 1'b0);
    push_req(0, 0, 0, 0, 0, 1'b0);
    push_req(11585, 0, 11585, 0, 3, 1'b0);
    push_req(11585, 0, 11585, 0, 0, 1'b0);
    push_req(0, 16384, 0, 0, 0, 1'b0);
    push_req(0, 0, 0, 16384, 5, 1'b0);
    push_req(-16384, -16384, -16384, -16384, 0, 1'b0);
    push_req(32767, 32767, 32767, 32767, 0, 1'b0);
    push_req(-32768, -32768, -32768, -32768, 0, 1'b0);
    push_req(32767, -32768, 32767, -32768, 1, 1'b0);
    push_req(1, 0, 0, 0, 0, 1'b0);
    push_req(0, 0, 0, -1, 0, 1'b0);
    push_req(0, 0, -1, 0, 0, 1'b0);
    push_req(1, -1, 1, -1, 11, 1'b0);
    push_req(0, 0, 0, 0, 0, 1'b0);
    push_req(16384, 16384, 16384, 16384, 0, 1'b0);
    push_req(-32768, 0, 0, 0, 0, 1'b0);
    push_req(0, -32768, 0, 0, 0, 1'b0);
    push_req(0, 0, -32768, 0, 2, 1'b0);
    push_req(0, 0, 0, 32767, 0, 1'b0);
    push_req(12000, 0, -9000, 0, 0, 1'b0);
    push_req(16384, 0, 0, 0, 0, 1'b0);

    calm = 1'b0;
    for (int i = N_DIRECTED; i < N_TOTAL; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(0, 2) == 0);
      pct = $urandom_range(0, 99);
      if (pct < 25) kind = K_RAW;
      else if (pct < 55) kind = K_UNIT;
      else if (pct < 70) kind = K_NEAR_ID;
      else if (pct < 82) kind = K_TINY;
      else if (pct < 95) kind = K_EXTREME;
      else kind = K_ZERO;
      gap = 0;
      if (i < QUIET_FROM && !calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
      push_req(pick_field(kind, 0), pick_field(kind, 1), pick_field(kind, 2),
               pick_field(kind, 3), gap, (i == DRAIN_A || i == DRAIN_B));
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_deltas.size() != 0 || due_orients.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Request side: offers the head of the pending list after its gap, and
  // holds a marked request back until every earlier result has arrived.
  always @(posedge clk) begin : drive_requests
    bit offer;
    offer = 1'b0;
    if (rst) begin
      delta_if.valid <= 1'b0;
      n_sent <= 0;
      gap_left = 0;
      gap_armed = 1'b0;
    end else begin
      if (delta_if.valid && delta_if.ready) begin
        due_orients.push_back(apply_delta(pending_deltas.pop_front()));
        n_sent <= n_sent + 1;
        gap_armed = 1'b0;
      end
      if (pending_deltas.size() != 0) begin
        if (!gap_armed) begin
          gap_left = pending_deltas[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(pending_deltas[0].drain && due_orients.size() != 0)) begin
          offer = 1'b1;
        end
      end
      delta_if.valid <= offer;
      delta_if.delta_w <= offer ? pending_deltas[0].w : FW'($urandom);
      delta_if.delta_x <= offer ? pending_deltas[0].x : FW'($urandom);
      delta_if.delta_y <= offer ? pending_deltas[0].y : FW'($urandom);
      delta_if.delta_z <= offer ? pending_deltas[0].z : FW'($urandom);
    end
  end

  // Result side pacing: random stall bursts, calm stretches, and one long
  // hold that lets the block back up into its request channel.
  always @(posedge clk) begin : pace_results
    if (rst) begin
      result_if.ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      rx_gap = 0;
      calm_left = 0;
    end else begin
      if (!hold_done && n_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        result_if.ready <= 1'b0;
      end else begin
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(200, 800);
        if (n_sent < QUIET_FROM && calm_left == 0 && $urandom_range(0, 7) == 0) begin
          rx_gap = $urandom_range(1, 11) - 1;
          result_if.ready <= 1'b0;
        end else begin
          result_if.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    orient_t got;
    orient_t want;
    bit bad;
    if (!rst && result_if.valid && result_if.ready) begin
      got.w = result_if.orient_w;
      got.x = result_if.orient_x;
      got.y = result_if.orient_y;
      got.z = result_if.orient_z;
      got.fwd = result_if.forward_term;
      got.dir_x_neg = result_if.dir_x_negative;
      got.dir_y_neg = result_if.dir_y_negative;
      if (due_orients.size() == 0) begin
        report_error($sformatf("result %0d arrived with no request outstanding", n_results));
      end else begin
        want = due_orients.pop_front();
        bad = (got.w !== want.w) || (got.x !== want.x) || (got.y !== want.y) ||
              (got.z !== want.z) || (got.fwd !== want.fwd) ||
              (got.dir_x_neg !== want.dir_x_neg) || (got.dir_y_neg !== want.dir_y_neg);
        if (bad) begin
          report_error($sformatf({"result %0d: expected w=%0d x=%0d y=%0d z=%0d fwd=%0d ",
                                  "xneg=%b yneg=%b, got w=%0d x=%0d y=%0d z=%0d fwd=%0d ",
                                  "xneg=%b yneg=%b"},
                                 n_results, want.w, want.x, want.y, want.z, want.fwd,
                                 want.dir_x_neg, want.dir_y_neg, got.w, got.x, got.y,
                                 got.z, got.fwd, got.dir_x_neg, got.dir_y_neg));
        end
      end
      n_results++;
    end
  end

endmodule
